@@ src/wdrb_pkg.sv @@
package wdrb_pkg;

  localparam int TAG_W           = 32;
  localparam int NUM_WORKERS_DEF = 8;
  localparam int WAIT_DEPTH_DEF  = 16;
  localparam int DONE_DEPTH_DEF  = 32;

  localparam logic [3:0] WORKERS_RESET = 4'd8;

  localparam logic OP_ARRIVE   = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  typedef enum logic [2:0] {
    KIND_DISPATCH = 3'd0,
    KIND_RELEASE  = 3'd1,
    KIND_PASS     = 3'd2,
    KIND_WAIT_OVF = 3'd3,
    KIND_OUT_OVF  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARRIVE,
    S_RM,
    S_CPL,
    S_POP,
    S_BI,
    S_BW_RD,
    S_BW_CMP,
    S_REL,
    S_REL_FRONT,
    S_REL_BND,
    S_INS_CHK,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic             opcode;
    logic [TAG_W-1:0] job_tag;
    logic             job_valid;
    logic [2:0]       worker_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       result_kind;
    logic [2:0]       target_worker;
    logic [TAG_W-1:0] result_tag;
    logic [TAG_W-1:0] previous_tag;
    logic             last_result;
  } out_item_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

@@ src/wdrb_cmp.sv @@
module wdrb_cmp (
  input  logic [wdrb_pkg::TAG_W-1:0] a_i,
  input  logic [wdrb_pkg::TAG_W-1:0] b_i,
  output wdrb_pkg::cmp_res_t         res_o
);
  import wdrb_pkg::*;

  always_comb begin
    res_o.lt = (a_i < b_i);
    res_o.eq = (a_i == b_i);
  end

endmodule

@@ src/wdrb_mem.sv @@
module wdrb_mem #(
  parameter int DEPTH = wdrb_pkg::WAIT_DEPTH_DEF,
  parameter int WIDTH = wdrb_pkg::TAG_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  import wdrb_pkg::*;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/worker_dispatch_reorder_buffer_top.sv @@
// Arrival: its one result (none when queued) is held in S_ARRIVE and sent out from S_FLUSH;
// the next request is taken only after S_FLUSH has returned to S_IDLE.
// Completion: its steps run one after another on the single shared tag comparator and the
// one read port of each store, and can stall on the output.
// One request is in work at a time; in_ready is high only between requests.
// Reset (synchronous): all workers free, both stores empty, workers_r = 8;
// the stores hold no clearing pass, so the block is ready right after reset.
module worker_dispatch_reorder_buffer_top #(
  parameter int NUM_WORKERS = wdrb_pkg::NUM_WORKERS_DEF,
  parameter int WAIT_DEPTH  = wdrb_pkg::WAIT_DEPTH_DEF,
  parameter int DONE_DEPTH  = wdrb_pkg::DONE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wdrb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wdrb_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);
  import wdrb_pkg::*;

  localparam int WIW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int WPW = $clog2(WAIT_DEPTH);
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam int DPW = $clog2(DONE_DEPTH);
  localparam int DCW = $clog2(DONE_DEPTH + 1);
  localparam int LW  = (WCW > DCW) ? WCW : DCW;

  state_t             state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  logic [3:0]         workers_r, workers_nxt;
  logic [NUM_WORKERS-1:0] busy_r, busy_nxt;
  logic [NUM_WORKERS-1:0] ifv_r, ifv_nxt;
  logic [TAG_W-1:0]   ift_r [NUM_WORKERS];
  logic [TAG_W-1:0]   ift_nxt [NUM_WORKERS];
  logic [TAG_W-1:0]   last_disp_r, last_disp_nxt;
  logic [WPW-1:0]     whead_r, whead_nxt, wtail_r, wtail_nxt, wp_r, wp_nxt;
  logic [WCW-1:0]     wcount_r, wcount_nxt;
  logic [DPW-1:0]     dhead_r, dhead_nxt, dtail_r, dtail_nxt, wpos_r, wpos_nxt;
  logic [DCW-1:0]     dcount_r, dcount_nxt, rel_r, rel_nxt;
  logic [WIW-1:0]     idx_r, idx_nxt;
  logic [LW-1:0]      left_r, left_nxt;
  logic [TAG_W-1:0]   bound_r, bound_nxt, cand_r, cand_nxt;
  logic               have_r, have_nxt, ins_pend_r, ins_pend_nxt;
  logic               cand_is_tag_r, cand_is_tag_nxt;
  out_item_t          hold_r, hold_nxt, out_r, out_nxt;
  logic               hold_vld_r, hold_vld_nxt, out_valid_r, out_valid_nxt;

  logic [4:0]         act_cnt;
  logic               free_found;
  logic [WIW-1:0]     free_idx;
  logic [4:0]         w_ext;
  logic [WIW-1:0]     w_idx;
  logic               w_in_range, w_act;
  logic               can_emit, emit;
  out_item_t          emit_res;

  logic [TAG_W-1:0]   cmp_a, cmp_b;
  cmp_res_t           cmp;

  logic               w_we, d_we;
  logic [WPW-1:0]     w_ra;
  logic [DPW-1:0]     d_ra, d_wa;
  logic [TAG_W-1:0]   d_wd, rdata_w, rdata_d;

  function automatic out_item_t mk_res(input kind_t k, input logic [2:0] w,
                                       input logic [TAG_W-1:0] tag,
                                       input logic [TAG_W-1:0] prev);
    out_item_t r;
    r.result_kind   = k;
    r.target_worker = w;
    r.result_tag    = tag;
    r.previous_tag  = prev;
    r.last_result   = 1'b0;
    return r;
  endfunction

  function automatic logic [WPW-1:0] w_inc(input logic [WPW-1:0] p);
    return (p == WPW'(WAIT_DEPTH - 1)) ? '0 : WPW'(p + 1'b1);
  endfunction

  function automatic logic [DPW-1:0] d_inc(input logic [DPW-1:0] p);
    return (p == DPW'(DONE_DEPTH - 1)) ? '0 : DPW'(p + 1'b1);
  endfunction

  function automatic logic [DPW-1:0] d_dec(input logic [DPW-1:0] p);
    return (p == '0) ? DPW'(DONE_DEPTH - 1) : DPW'(p - 1'b1);
  endfunction

  wdrb_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp)
  );

  wdrb_mem #(.DEPTH(WAIT_DEPTH), .WIDTH(TAG_W)) u_wait_mem (
    .clk   (clk),
    .we    (w_we),
    .waddr (wtail_r),
    .wdata (item_r.job_tag),
    .raddr (w_ra),
    .rdata (rdata_w)
  );

  wdrb_mem #(.DEPTH(DONE_DEPTH), .WIDTH(TAG_W)) u_done_mem (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_wa),
    .wdata (d_wd),
    .raddr (d_ra),
    .rdata (rdata_d)
  );

  // Clamp the worker count to 1..NUM_WORKERS.
  always_comb begin
    if (workers_r == '0) begin
      act_cnt = 5'd1;
    end else if (5'(workers_r) > 5'(NUM_WORKERS)) begin
      act_cnt = 5'(NUM_WORKERS);
    end else begin
      act_cnt = 5'(workers_r);
    end
  end

  // Lowest-numbered free active worker.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = NUM_WORKERS - 1; k >= 0; k--) begin
      if (!busy_r[k] && (5'(k) < act_cnt)) begin
        free_found = 1'b1;
        free_idx   = WIW'(k);
      end
    end
  end

  assign w_ext      = 5'(item_r.worker_index);
  assign w_in_range = (w_ext < 5'(NUM_WORKERS));
  assign w_act      = (w_ext < act_cnt);
  assign w_idx      = w_ext[WIW-1:0];

  // Operand select for the shared comparator.
  always_comb begin
    cmp_a = item_r.job_tag;
    cmp_b = bound_r;
    case (state_r)
      S_RM: begin
        cmp_a = ift_r[idx_r];
        cmp_b = item_r.job_tag;
      end
      S_BI: begin
        cmp_a = ift_r[idx_r];
        cmp_b = bound_r;
      end
      S_BW_CMP: begin
        cmp_a = rdata_w;
        cmp_b = bound_r;
      end
      S_REL_FRONT: begin
        cmp_a = item_r.job_tag;
        cmp_b = rdata_d;
      end
      S_REL_BND: begin
        cmp_a = cand_r;
        cmp_b = bound_r;
      end
      S_INS_CMP: begin
        cmp_a = item_r.job_tag;
        cmp_b = rdata_d;
      end
      default: begin
        cmp_a = item_r.job_tag;
        cmp_b = bound_r;
      end
    endcase
  end

  assign w_ra = (state_r == S_BW_RD) ? wp_r : whead_r;
  assign d_ra = (state_r == S_INS_RD) ? d_dec(wpos_r) : dhead_r;

  assign can_emit = !hold_vld_r || !out_valid_r || out_ready;

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    workers_nxt     = workers_r;
    busy_nxt        = busy_r;
    ifv_nxt         = ifv_r;
    ift_nxt         = ift_r;
    last_disp_nxt   = last_disp_r;
    whead_nxt       = whead_r;
    wtail_nxt       = wtail_r;
    wcount_nxt      = wcount_r;
    wp_nxt          = wp_r;
    dhead_nxt       = dhead_r;
    dtail_nxt       = dtail_r;
    dcount_nxt      = dcount_r;
    wpos_nxt        = wpos_r;
    rel_nxt         = rel_r;
    idx_nxt         = idx_r;
    left_nxt        = left_r;
    bound_nxt       = bound_r;
    have_nxt        = have_r;
    cand_nxt        = cand_r;
    cand_is_tag_nxt = cand_is_tag_r;
    ins_pend_nxt    = ins_pend_r;
    hold_nxt        = hold_r;
    hold_vld_nxt    = hold_vld_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    emit            = 1'b0;
    emit_res        = '0;
    w_we            = 1'b0;
    d_we            = 1'b0;
    d_wa            = wpos_r;
    d_wd            = item_r.job_tag;
    in_ready        = 1'b0;

    if (cfg_valid) begin
      workers_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_data;
          idx_nxt   = '0;
          state_nxt = (in_data.opcode == OP_ARRIVE) ? S_ARRIVE : S_RM;
        end
      end
      S_ARRIVE: begin
        if (!item_r.job_valid) begin
          emit     = 1'b1;
          emit_res = mk_res(KIND_PASS, 3'd0, item_r.job_tag, '0);
        end else if (free_found) begin
          busy_nxt[free_idx] = 1'b1;
          ifv_nxt[free_idx]  = 1'b1;
          ift_nxt[free_idx]  = item_r.job_tag;
          last_disp_nxt      = item_r.job_tag;
          emit               = 1'b1;
          emit_res = mk_res(KIND_DISPATCH, 3'(free_idx), item_r.job_tag, last_disp_r);
        end else if (wcount_r < WCW'(WAIT_DEPTH)) begin
          w_we       = 1'b1;
          wtail_nxt  = w_inc(wtail_r);
          wcount_nxt = WCW'(wcount_r + 1'b1);
        end else begin
          emit     = 1'b1;
          emit_res = mk_res(KIND_WAIT_OVF, 3'd0, item_r.job_tag, '0);
        end
        state_nxt = S_FLUSH;
      end
      S_RM: begin
        if (ifv_r[idx_r] && cmp.eq) begin
          ifv_nxt[idx_r] = 1'b0;
          state_nxt      = S_CPL;
        end else if (idx_r == WIW'(NUM_WORKERS - 1)) begin
          state_nxt = S_CPL;
        end else begin
          idx_nxt = WIW'(idx_r + 1'b1);
        end
      end
      S_CPL: begin
        idx_nxt   = '0;
        have_nxt  = 1'b0;
        state_nxt = S_BI;
        if (w_in_range) begin
          if (w_act && (wcount_r != '0)) begin
            state_nxt = S_POP;
          end else begin
            busy_nxt[w_idx] = 1'b0;
          end
        end
      end
      S_POP: begin
        busy_nxt[w_idx] = 1'b1;
        ifv_nxt[w_idx]  = 1'b1;
        ift_nxt[w_idx]  = rdata_w;
        last_disp_nxt   = rdata_w;
        emit            = 1'b1;
        emit_res        = mk_res(KIND_DISPATCH, item_r.worker_index, rdata_w, last_disp_r);
        whead_nxt       = w_inc(whead_r);
        wcount_nxt      = WCW'(wcount_r - 1'b1);
        state_nxt       = S_BI;
      end
      S_BI: begin
        if (ifv_r[idx_r] && (!have_r || cmp.lt)) begin
          bound_nxt = ift_r[idx_r];
          have_nxt  = 1'b1;
        end
        if (idx_r == WIW'(NUM_WORKERS - 1)) begin
          if (wcount_r != '0) begin
            wp_nxt    = whead_r;
            left_nxt  = LW'(wcount_r);
            state_nxt = S_BW_RD;
          end else begin
            ins_pend_nxt = 1'b1;
            rel_nxt      = '0;
            state_nxt    = S_REL;
          end
        end else begin
          idx_nxt = WIW'(idx_r + 1'b1);
        end
      end
      S_BW_RD: begin
        state_nxt = S_BW_CMP;
      end
      S_BW_CMP: begin
        if (!have_r || cmp.lt) begin
          bound_nxt = rdata_w;
          have_nxt  = 1'b1;
        end
        wp_nxt   = w_inc(wp_r);
        left_nxt = LW'(left_r - 1'b1);
        if (left_r == LW'(1)) begin
          ins_pend_nxt = 1'b1;
          rel_nxt      = '0;
          state_nxt    = S_REL;
        end else begin
          state_nxt = S_BW_RD;
        end
      end
      S_REL: begin
        if (rel_r == DCW'(DONE_DEPTH)) begin
          state_nxt = S_INS_CHK;
        end else if (dcount_r != '0) begin
          state_nxt = S_REL_FRONT;
        end else if (ins_pend_r) begin
          cand_nxt        = item_r.job_tag;
          cand_is_tag_nxt = 1'b1;
          state_nxt       = S_REL_BND;
        end else begin
          state_nxt = S_INS_CHK;
        end
      end
      S_REL_FRONT: begin
        // A stored tag equal to the completed one goes out first.
        if (ins_pend_r && cmp.lt) begin
          cand_nxt        = item_r.job_tag;
          cand_is_tag_nxt = 1'b1;
        end else begin
          cand_nxt        = rdata_d;
          cand_is_tag_nxt = 1'b0;
        end
        state_nxt = S_REL_BND;
      end
      S_REL_BND: begin
        if (have_r && !cmp.lt) begin
          state_nxt = S_INS_CHK;
        end else if (can_emit) begin
          emit     = 1'b1;
          emit_res = mk_res(KIND_RELEASE, 3'd0, cand_r, '0);
          if (cand_is_tag_r) begin
            ins_pend_nxt = 1'b0;
          end else begin
            dhead_nxt  = d_inc(dhead_r);
            dcount_nxt = DCW'(dcount_r - 1'b1);
          end
          rel_nxt   = DCW'(rel_r + 1'b1);
          state_nxt = S_REL;
        end
      end
      S_INS_CHK: begin
        if (!ins_pend_r) begin
          state_nxt = S_FLUSH;
        end else if (dcount_r == DCW'(DONE_DEPTH)) begin
          // Store full and nothing released: drop the completed tag.
          if (can_emit) begin
            emit      = 1'b1;
            emit_res  = mk_res(KIND_OUT_OVF, 3'd0, item_r.job_tag, '0);
            state_nxt = S_FLUSH;
          end
        end else begin
          wpos_nxt  = dtail_r;
          left_nxt  = LW'(dcount_r);
          state_nxt = (dcount_r != '0) ? S_INS_RD : S_INS_PUT;
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        d_we = 1'b1;
        if (cmp.lt) begin
          // Shift the larger entry up one place.
          d_wd     = rdata_d;
          wpos_nxt = d_dec(wpos_r);
          left_nxt = LW'(left_r - 1'b1);
          state_nxt = (left_r == LW'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          dtail_nxt  = d_inc(dtail_r);
          dcount_nxt = DCW'(dcount_r + 1'b1);
          state_nxt  = S_FLUSH;
        end
      end
      S_INS_PUT: begin
        d_we       = 1'b1;
        dtail_nxt  = d_inc(dtail_r);
        dcount_nxt = DCW'(dcount_r + 1'b1);
        state_nxt  = S_FLUSH;
      end
      S_FLUSH: begin
        if (!hold_vld_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_nxt             = hold_r;
          out_nxt.last_result = 1'b1;
          out_valid_nxt       = 1'b1;
          hold_vld_nxt        = 1'b0;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Hold one result back so the last one of a request can be marked.
    if (emit) begin
      if (hold_vld_r) begin
        out_nxt             = hold_r;
        out_nxt.last_result = 1'b0;
        out_valid_nxt       = 1'b1;
      end
      hold_nxt     = emit_res;
      hold_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      workers_r   <= WORKERS_RESET;
      busy_r      <= '0;
      ifv_r       <= '0;
      last_disp_r <= '0;
      whead_r     <= '0;
      wtail_r     <= '0;
      wcount_r    <= '0;
      dhead_r     <= '0;
      dtail_r     <= '0;
      dcount_r    <= '0;
      have_r      <= 1'b0;
      ins_pend_r  <= 1'b0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      workers_r   <= workers_nxt;
      busy_r      <= busy_nxt;
      ifv_r       <= ifv_nxt;
      last_disp_r <= last_disp_nxt;
      whead_r     <= whead_nxt;
      wtail_r     <= wtail_nxt;
      wcount_r    <= wcount_nxt;
      dhead_r     <= dhead_nxt;
      dtail_r     <= dtail_nxt;
      dcount_r    <= dcount_nxt;
      have_r      <= have_nxt;
      ins_pend_r  <= ins_pend_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r        <= item_nxt;
    ift_r         <= ift_nxt;
    wp_r          <= wp_nxt;
    wpos_r        <= wpos_nxt;
    rel_r         <= rel_nxt;
    idx_r         <= idx_nxt;
    left_r        <= left_nxt;
    bound_r       <= bound_nxt;
    cand_r        <= cand_nxt;
    cand_is_tag_r <= cand_is_tag_nxt;
    hold_r        <= hold_nxt;
    out_r         <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !hold_vld_r)
    else $error("held result left over when taking a new request");

  a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wcount_r <= WCW'(WAIT_DEPTH))
    else $error("waiting count beyond depth");

  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dcount_r <= DCW'(DONE_DEPTH))
    else $error("done store count beyond depth");

  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.opcode == OP_ARRIVE) && !in_data.job_valid)
    |-> ##2 (hold_vld_r && (hold_r.result_kind == KIND_PASS)))
    else $error("invalid job not passed through");

endmodule

@@ tb/worker_dispatch_reorder_buffer_top_tb.sv @@
`timescale 1ns / 100ps

module worker_dispatch_reorder_buffer_top_tb;
  import wdrb_pkg::*;

  localparam int NUM_W         = NUM_WORKERS_DEF;
  localparam int SETTLE_CYCLES = 300;
  localparam int LONG_HOLD     = 600;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t res;
  } row_t;

  // Typed rows hold a result worked out by hand from the rows before them; the rest use the predictor.
  localparam row_t DIRECTED_ROWS [19] = '{
    '{'{OP_ARRIVE,   32'hFFFF_FFFF, 1'b0, 3'd0}, 1'b1,
      '{KIND_PASS,     3'd0, 32'hFFFF_FFFF, 32'd0, 1'b1}},
    '{'{OP_ARRIVE,   32'h0000_0000, 1'b0, 3'd7}, 1'b1,
      '{KIND_PASS,     3'd0, 32'h0000_0000, 32'd0, 1'b1}},
    '{'{OP_ARRIVE,   32'h0000_0010, 1'b1, 3'd0}, 1'b1,
      '{KIND_DISPATCH, 3'd0, 32'h0000_0010, 32'd0, 1'b1}},
    '{'{OP_ARRIVE,   32'hFFFF_FFFF, 1'b1, 3'd5}, 1'b1,
      '{KIND_DISPATCH, 3'd1, 32'hFFFF_FFFF, 32'h0000_0010, 1'b1}},
    '{'{OP_COMPLETE, 32'hFFFF_FFFF, 1'b0, 3'd1}, 1'b0, '0},
    '{'{OP_COMPLETE, 32'h0000_0010, 1'b0, 3'd0}, 1'b0, '0},
    '{'{OP_COMPLETE, 32'h0000_0005, 1'b1, 3'd7}, 1'b0, '0},
    '{'{OP_ARRIVE,   32'h0000_0000, 1'b1, 3'd0}, 1'b1,
      '{KIND_DISPATCH, 3'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1}},
    '{'{OP_COMPLETE, 32'h0000_0000, 1'b0, 3'd0}, 1'b0, '0},
    '{'{OP_ARRIVE,   32'h0000_0020, 1'b1, 3'd0}, 1'b0, '0},
    '{'{OP_ARRIVE,   32'h0000_0020, 1'b1, 3'd0}, 1'b0, '0},
    '{'{OP_ARRIVE,   32'h0000_0030, 1'b1, 3'd0}, 1'b0, '0},
    '{'{OP_COMPLETE, 32'h0000_0020, 1'b0, 3'd1}, 1'b0, '0},
    '{'{OP_COMPLETE, 32'h0000_0020, 1'b0, 3'd0}, 1'b0, '0},
    '{'{OP_COMPLETE, 32'h0000_0030, 1'b0, 3'd2}, 1'b0, '0},
    '{'{OP_ARRIVE,   32'h0000_0040, 1'b1, 3'd0}, 1'b0, '0},
    '{'{OP_COMPLETE, 32'h0000_0099, 1'b0, 3'd0}, 1'b0, '0},
    '{'{OP_ARRIVE,   32'h0000_0050, 1'b1, 3'd0}, 1'b0, '0},
    '{'{OP_COMPLETE, 32'h0000_0050, 1'b0, 3'd0}, 1'b0, '0}
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data  = WORKERS_RESET;

  // Predictor state
  logic [3:0]       worker_limit = WORKERS_RESET;
  bit               w_busy      [NUM_W] = '{default: 1'b0};
  bit               w_job_valid [NUM_W] = '{default: 1'b0};
  logic [TAG_W-1:0] w_job_tag   [NUM_W] = '{default: '0};
  logic [TAG_W-1:0] queued_jobs[$];
  logic [TAG_W-1:0] held_done[$];
  logic [TAG_W-1:0] prev_dispatch_tag = '0;

  out_item_t step_results[$];
  out_item_t awaited_results[$];

  logic [TAG_W-1:0] next_tag = 32'h0000_0100;
  int burst_left    = 0;
  int hold_asks     = 0;
  int holds_done    = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int mismatches    = 0;
  int kind_seen [5] = '{default: 0};
  int cycle_count   = 0;

  worker_dispatch_reorder_buffer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int active_limit();
    if (worker_limit == 4'd0) return 1;
    if (worker_limit > NUM_W) return NUM_W;
    return int'(worker_limit);
  endfunction

  function automatic out_item_t make_result(kind_t kind, logic [2:0] wkr,
                                            logic [TAG_W-1:0] tag, logic [TAG_W-1:0] prev);
    out_item_t r;
    r.result_kind   = kind;
    r.target_worker = wkr;
    r.result_tag    = tag;
    r.previous_tag  = prev;
    r.last_result   = 1'b0;
    return r;
  endfunction

  function automatic void dispatch_job(int wkr, logic [TAG_W-1:0] tag);
    w_busy[wkr]      = 1'b1;
    w_job_valid[wkr] = 1'b1;
    w_job_tag[wkr]   = tag;
    step_results = {step_results,
                    make_result(KIND_DISPATCH, wkr[2:0], tag, prev_dispatch_tag)};
    prev_dispatch_tag = tag;
  endfunction

  // Work out the results of one request and advance the predictor state.
  function automatic void compute_dispatch_and_release(in_item_t req);
    logic [TAG_W-1:0] tag;
    logic [TAG_W-1:0] bound;
    logic [TAG_W-1:0] merged[$];
    bit   found;
    bit   have_bound;
    int   i;
    int   wkr;
    int   pos;
    int   rel;

    step_results.delete();
    tag = req.job_tag;
    if (req.opcode == OP_ARRIVE) begin
      if (!req.job_valid) begin
        step_results = {step_results, make_result(KIND_PASS, 3'd0, tag, '0)};
      end else begin
        wkr = -1;
        for (i = active_limit() - 1; i >= 0; i--)
          if (!w_busy[i]) wkr = i;
        if (wkr >= 0)
          dispatch_job(wkr, tag);
        else if (queued_jobs.size() < WAIT_DEPTH_DEF)
          queued_jobs = {queued_jobs, tag};
        else
          step_results = {step_results, make_result(KIND_WAIT_OVF, 3'd0, tag, '0)};
      end
    end else begin
      found = 1'b0;
      for (i = 0; i < NUM_W; i++) begin
        if (!found && w_job_valid[i] && w_job_tag[i] == tag) begin
          w_job_valid[i] = 1'b0;
          found = 1'b1;
        end
      end
      wkr = int'(req.worker_index);
      if (wkr < active_limit() && queued_jobs.size() > 0)
        dispatch_job(wkr, queued_jobs.pop_front());
      else
        w_busy[wkr] = 1'b0;

      // Insert after any equal tags.
      merged = held_done;
      pos = 0;
      while (pos < merged.size() && merged[pos] <= tag) pos++;
      merged.insert(pos, tag);

      have_bound = 1'b0;
      bound = '0;
      for (i = 0; i < NUM_W; i++) begin
        if (w_job_valid[i] && (!have_bound || w_job_tag[i] < bound)) begin
          bound = w_job_tag[i];
          have_bound = 1'b1;
        end
      end
      foreach (queued_jobs[j]) begin
        if (!have_bound || queued_jobs[j] < bound) begin
          bound = queued_jobs[j];
          have_bound = 1'b1;
        end
      end

      rel = 0;
      while (rel < merged.size() && rel < DONE_DEPTH_DEF &&
             (!have_bound || merged[rel] < bound))
        rel++;

      if (merged.size() > DONE_DEPTH_DEF && rel == 0) begin
        step_results = {step_results, make_result(KIND_OUT_OVF, 3'd0, tag, '0)};
      end else begin
        repeat (rel)
          step_results = {step_results,
                          make_result(KIND_RELEASE, 3'd0, merged.pop_front(), '0)};
        held_done = merged;
      end
    end
    if (step_results.size() > 0)
      step_results[step_results.size() - 1].last_result = 1'b1;
  endfunction

  function automatic logic [TAG_W-1:0] take_tag();
    // Repeat the previous tag now and then to exercise equal tags.
    if ($urandom_range(0, 9) != 0) next_tag = next_tag + $urandom_range(1, 300);
    return next_tag;
  endfunction

  task automatic send_request(input in_item_t req, input logic typed, input out_item_t typed_res);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    compute_dispatch_and_release(req);
    if (typed)
      awaited_results = {awaited_results, typed_res};
    else
      foreach (step_results[i]) awaited_results = {awaited_results, step_results[i]};
    sent_count++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // Let the block finish everything, including completions that emit nothing.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_worker_limit(input logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    worker_limit = value;
  endtask

  // Retire every in-flight and waiting job.
  task automatic drain_jobs();
    in_item_t req;
    int i;
    int wkr;
    int guard;

    guard = 0;
    while (guard < 80) begin
      wkr = -1;
      for (i = NUM_W - 1; i >= 0; i--)
        if (w_job_valid[i]) wkr = i;
      req = '0;
      req.opcode = OP_COMPLETE;
      if (wkr >= 0) begin
        req.worker_index = wkr[2:0];
        req.job_tag = w_job_tag[wkr];
      end else if (queued_jobs.size() > 0) begin
        req.worker_index = 3'd0;
        req.job_tag = take_tag();
      end else begin
        break;
      end
      send_request(req, 1'b0, '0);
      guard++;
    end
  endtask

  // Hold one low tag in flight while completions fill the done store past its depth.
  task automatic flood_done_store();
    in_item_t req;
    int i;
    int hold_w;

    drain_jobs();
    req = '0;
    req.opcode = OP_ARRIVE;
    req.job_valid = 1'b1;
    req.job_tag = take_tag();
    send_request(req, 1'b0, '0);
    hold_w = 0;
    for (i = NUM_W - 1; i >= 0; i--)
      if (w_job_valid[i] && w_job_tag[i] == req.job_tag) hold_w = i;
    repeat (DONE_DEPTH_DEF + 2) begin
      req = '0;
      req.opcode = OP_COMPLETE;
      req.job_tag = take_tag() + 1;
      req.worker_index = 3'((hold_w + $urandom_range(1, NUM_W - 1)) % NUM_W);
      send_request(req, 1'b0, '0);
    end
    req = '0;
    req.opcode = OP_COMPLETE;
    req.job_tag = w_job_tag[hold_w];
    req.worker_index = hold_w[2:0];
    send_request(req, 1'b0, '0);
  endtask

  task automatic fill_wait_queue(input int count);
    in_item_t req;
    repeat (count) begin
      req = '0;
      req.opcode = OP_ARRIVE;
      req.job_valid = 1'b1;
      req.job_tag = take_tag();
      req.worker_index = 3'($urandom_range(0, 7));
      send_request(req, 1'b0, '0);
    end
  endtask

  // Mostly well-formed arrive/complete traffic, with some noise mixed in.
  task automatic run_traffic(input int count);
    in_item_t req;
    int live[$];
    int i;
    int pick;

    repeat (count) begin
      live.delete();
      for (i = 0; i < NUM_W; i++)
        if (w_job_valid[i]) live = {live, i};
      req = '0;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        req.opcode = 1'($urandom_range(0, 1));
        req.job_tag = $urandom();
        req.job_valid = 1'($urandom_range(0, 1));
        req.worker_index = 3'($urandom_range(0, 7));
      end else if (live.size() > 0 && (pick < 55 || queued_jobs.size() >= WAIT_DEPTH_DEF)) begin
        i = live[$urandom_range(0, live.size() - 1)];
        req.opcode = OP_COMPLETE;
        req.job_tag = w_job_tag[i];
        req.job_valid = 1'($urandom_range(0, 1));
        req.worker_index = i[2:0];
      end else begin
        req.opcode = OP_ARRIVE;
        req.job_valid = 1'b1;
        req.job_tag = take_tag();
        req.worker_index = 3'($urandom_range(0, 7));
      end
      send_request(req, 1'b0, '0);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[r])
      send_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
    wait_idle();

    write_worker_limit(4'd15);
    flood_done_store();
    run_traffic(50);
    wait_idle();

    // Workers above the limit still hold jobs here.
    write_worker_limit(4'd3);
    run_traffic(60);
    wait_idle();

    write_worker_limit(4'd0);
    drain_jobs();
    hold_asks <= hold_asks + 1;
    fill_wait_queue(WAIT_DEPTH_DEF + 2);
    run_traffic(40);
    wait_idle();

    write_worker_limit(4'd1);
    next_tag = $urandom();
    run_traffic(40);
    wait_idle();

    write_worker_limit(4'd8);
    hold_asks <= hold_asks + 1;
    run_traffic(70);
    drain_jobs();
    wait_idle();

    if (awaited_results.size() != 0) mismatches++;
    $display("Sent %0d requests over worker limits 8, 15, 3, 0, 1, 8; checked %0d results.",
             sent_count, checked_count);
    $display("Results by kind: dispatch %0d, release %0d, pass %0d, wait ovf %0d, out ovf %0d.",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: switches between always ready, random stalls and a fixed pattern, and holds off when asked.
  initial begin : receiver
    int mode;
    int span;
    int hold_left;
    logic [7:0] rx_pattern;

    mode = 0;
    span = 0;
    hold_left = 0;
    rx_pattern = 8'hFF;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_asks != holds_done) begin
        hold_left = LONG_HOLD;
        holds_done++;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 120);
        rx_pattern = 8'($urandom_range(0, 255)) | 8'h01;
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= rx_pattern[span % 8];
        endcase
      end
    end
  end

  function automatic string fields_off(out_item_t want, out_item_t got);
    string s;
    s = "";
    if (want.result_kind !== got.result_kind) s = {s, " result_kind"};
    if (want.target_worker !== got.target_worker) s = {s, " target_worker"};
    if (want.result_tag !== got.result_tag) s = {s, " result_tag"};
    if (want.previous_tag !== got.previous_tag) s = {s, " previous_tag"};
    if (want.last_result !== got.last_result) s = {s, " last_result"};
    return s;
  endfunction

  function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"Mismatch %0d: %s exp kind=%0d wkr=%0d tag=%h prev=%h last=%0b",
                " | got kind=%0d wkr=%0d tag=%h prev=%h last=%0b"},
               mismatches, what, want.result_kind, want.target_worker, want.result_tag,
               want.previous_tag, want.last_result, got.result_kind, got.target_worker,
               got.result_tag, got.previous_tag, got.last_result);
  endfunction

  out_item_t want_res;
  string     diff;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      checked_count++;
      if (out_data.result_kind < 3'd5) kind_seen[out_data.result_kind]++;
      if (awaited_results.size() == 0) begin
        note_mismatch("result with nothing awaited:", '0, out_data);
      end else begin
        want_res = awaited_results.pop_front();
        diff = fields_off(want_res, out_data);
        if (diff != "") note_mismatch({"wrong", diff, ":"}, want_res, out_data);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited", cycle_count,
               awaited_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
